// ===== hdl/sii_pkg.sv =====
// Shared types and constants of the subpixel image interpolator.
package sii_pkg;

	localparam int COORD_W = 16;
	localparam int OUT_W   = 18;
	localparam int CNT_W   = 4;
	localparam int K_W     = 3;
	localparam int PASS_W  = 3;

	localparam logic [1:0] MODE_LINEAR  = 2'd0;
	localparam logic [1:0] MODE_CUBIC   = 2'd1;
	localparam logic [1:0] MODE_QUINTIC = 2'd2;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_READ,
		S_DRAIN,
		S_COEF,
		S_MUL,
		S_ADD,
		S_FIN,
		S_DONE
	} sii_state_t;

	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic [CNT_W-1:0]  cnt;
		logic              coef;
		logic              mul;
		logic              add;
		logic              fin;
		logic [K_W-1:0]    k;
		logic [PASS_W-1:0] pass;
	} sii_cmd_t;

	typedef struct packed {
		logic           is_lin;
		logic           bad_img;
		logic [K_W-1:0] deg;
	} sii_stat_t;

endpackage

// ===== hdl/sii_ctrl.sv =====
// Controller state machine: sequences reads, Horner steps and result hand-off.
module sii_ctrl
	import sii_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      kind,
	input  logic      slot_free,
	input  sii_stat_t stat,
	output logic      in_ready,
	output logic      push,
	output sii_cmd_t  cmd
);

	sii_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [K_W-1:0]    k_q, k_d;
	logic [PASS_W-1:0] pass_q, pass_d;
	logic [CNT_W-1:0]  last_cnt;
	logic [PASS_W-1:0] n_cols;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
			pass_q  <= pass_d;
		end
	end

	assign last_cnt = stat.is_lin ? CNT_W'(3) : CNT_W'(15);
	assign n_cols   = stat.is_lin ? PASS_W'(2) : PASS_W'(4);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		k_d      = k_q;
		pass_d   = pass_q;
		in_ready = 1'b0;
		push     = 1'b0;
		cmd      = '0;
		cmd.cnt  = cnt_q;
		cmd.k    = k_q;
		cmd.pass = pass_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && kind == KIND_QUERY)
					state_d = S_START;
			end
			S_START: begin
				cnt_d   = '0;
				state_d = stat.bad_img ? S_DONE : S_READ;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == last_cnt)
					state_d = S_DRAIN;
				else
					cnt_d = cnt_q + CNT_W'(1);
			end
			S_DRAIN: begin
				pass_d  = '0;
				state_d = S_COEF;
			end
			S_COEF: begin
				cmd.coef = 1'b1;
				k_d      = stat.deg - K_W'(1);
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				if (k_q == '0)
					state_d = S_FIN;
				else begin
					k_d     = k_q - K_W'(1);
					state_d = S_MUL;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				if (pass_q == n_cols)
					state_d = S_DONE;
				else begin
					pass_d  = pass_q + PASS_W'(1);
					state_d = S_COEF;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					push    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hdl/sii_datapath.sv =====
// Datapath: pixel store, neighbour addressing with border clamp, Horner unit.
module sii_datapath
	import sii_pkg::*;
#(
	parameter int IMG_WIDTH  = 256,
	parameter int IMG_HEIGHT = 256,
	parameter int NUM_IMAGES = 2,
	parameter int FRAC_BITS  = 8,
	parameter int PIXEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sii_cmd_t                cmd,
	input  logic [1:0]              mode,
	input  logic                    kind,
	input  logic                    image_select,
	input  logic [7:0]              pixel_col,
	input  logic [7:0]              pixel_row,
	input  logic [7:0]              pixel_value,
	input  logic [COORD_W-1:0]      x_coord,
	input  logic [COORD_W-1:0]      y_coord,
	output sii_stat_t               stat,
	output logic signed [OUT_W-1:0] result,
	output logic                    flag
);

	localparam int DEPTH  = NUM_IMAGES * IMG_WIDTH * IMG_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IX_W   = COORD_W - FRAC_BITS;
	localparam int ACC_W  = PIXEL_BITS + FRAC_BITS + 16;
	localparam int PROD_W = ACC_W + FRAC_BITS + 1;

	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	logic [PIXEL_BITS-1:0] mem [DEPTH];
	logic [PIXEL_BITS-1:0] rdata_s1;
	logic                  rdv_s1;
	logic [1:0]            ra_s1, rb_s1;

	logic                  img_q;
	logic [IX_W-1:0]       ix_q, iy_q;
	logic [FRAC_BITS-1:0]  ux_q, uy_q;
	logic                  lin_q, quin_q, bad_q, flag_q;

	logic [PIXEL_BITS-1:0] grid_q [4][4];
	acc_t                  col_q [4];
	acc_t                  c_q [6];
	acc_t                  acc_q;
	prod_t                 prod_s1;
	logic signed [OUT_W-1:0] res_q;

	logic [1:0]            ra, rb;
	int                    cx, ry, wr_addr, rd_addr;
	logic                  clamped, wr_ok;
	logic [ADDR_W-1:0]     addr;
	acc_t                  p [4];
	acc_t                  c [6];
	logic [FRAC_BITS-1:0]  u_cur;
	prod_t                 rsum;
	acc_t                  fin;
	logic                  x_pass;

	assign stat.is_lin  = lin_q;
	assign stat.bad_img = bad_q;
	assign stat.deg     = lin_q ? K_W'(1) : (quin_q ? K_W'(5) : K_W'(3));
	assign result       = res_q;
	assign flag         = flag_q;

	// Neighbour index and clamp; bilinear walks 2x2 from the base point.
	always_comb begin
		ra = lin_q ? {1'b0, cmd.cnt[1]} : cmd.cnt[3:2];
		rb = lin_q ? {1'b0, cmd.cnt[0]} : cmd.cnt[1:0];
		cx = int'(ix_q) + int'(ra) - (lin_q ? 0 : 1);
		ry = int'(iy_q) + int'(rb) - (lin_q ? 0 : 1);
		clamped = 1'b0;
		if (cx < 0) begin
			cx = 0;
			clamped = 1'b1;
		end else if (cx >= IMG_WIDTH) begin
			cx = IMG_WIDTH - 1;
			clamped = 1'b1;
		end
		if (ry < 0) begin
			ry = 0;
			clamped = 1'b1;
		end else if (ry >= IMG_HEIGHT) begin
			ry = IMG_HEIGHT - 1;
			clamped = 1'b1;
		end
		rd_addr = int'(img_q) * IMG_WIDTH * IMG_HEIGHT + ry * IMG_WIDTH + cx;
		wr_addr = int'(image_select) * IMG_WIDTH * IMG_HEIGHT
			+ int'(pixel_row) * IMG_WIDTH + int'(pixel_col);
		wr_ok = cmd.load && kind == KIND_WRITE && int'(image_select) < NUM_IMAGES
			&& int'(pixel_col) < IMG_WIDTH && int'(pixel_row) < IMG_HEIGHT;
		addr = cmd.rd_en ? rd_addr[ADDR_W-1:0] : wr_addr[ADDR_W-1:0];
	end

	// Single-port store: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_ok)
			mem[addr] <= PIXEL_BITS'(pixel_value);
		if (cmd.rd_en)
			rdata_s1 <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rdv_s1 <= 1'b0;
		else
			rdv_s1 <= cmd.rd_en;
	end

	// Coefficient set (doubled) for the current pass.
	always_comb begin
		x_pass = cmd.pass == PASS_W'(lin_q ? 2 : 4);
		for (int i = 0; i < 4; i++)
			p[i] = x_pass ? col_q[i]
				: acc_t'({grid_q[cmd.pass[1:0]][i], FRAC_BITS'(0)});
		for (int i = 0; i < 6; i++)
			c[i] = '0;
		if (lin_q) begin
			c[1] = acc_t'(2) * (p[1] - p[0]);
			c[0] = acc_t'(2) * p[0];
		end else if (quin_q) begin
			c[5] = acc_t'(2) * p[0] - acc_t'(6) * p[1] + acc_t'(6) * p[2]
				- acc_t'(2) * p[3];
			c[4] = acc_t'(5) * p[3] - acc_t'(5) * p[0] + acc_t'(15) * p[1]
				- acc_t'(15) * p[2];
			c[3] = acc_t'(3) * p[0] - acc_t'(9) * p[1] + acc_t'(9) * p[2]
				- acc_t'(3) * p[3];
			c[2] = p[0] - acc_t'(2) * p[1] + p[2];
			c[1] = p[2] - p[0];
			c[0] = acc_t'(2) * p[1];
		end else begin
			c[3] = p[3] - p[0] + acc_t'(3) * p[1] - acc_t'(3) * p[2];
			c[2] = acc_t'(2) * p[0] - acc_t'(5) * p[1] + acc_t'(4) * p[2] - p[3];
			c[1] = p[2] - p[0];
			c[0] = acc_t'(2) * p[1];
		end
		u_cur = x_pass ? ux_q : uy_q;
		rsum  = prod_s1 + (prod_t'(1) <<< (FRAC_BITS - 1));
		fin   = (acc_q + acc_t'(1)) >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q  <= 1'b0;
			quin_q <= 1'b0;
			bad_q  <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				lin_q  <= mode == MODE_LINEAR;
				quin_q <= mode == MODE_QUINTIC;
				bad_q  <= int'(image_select) >= NUM_IMAGES;
				flag_q <= int'(image_select) >= NUM_IMAGES;
			end else if (cmd.rd_en && clamped)
				flag_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			img_q <= image_select;
			ix_q  <= x_coord[COORD_W-1:FRAC_BITS];
			iy_q  <= y_coord[COORD_W-1:FRAC_BITS];
			ux_q  <= x_coord[FRAC_BITS-1:0];
			uy_q  <= y_coord[FRAC_BITS-1:0];
			res_q <= '0;
		end
		if (cmd.rd_en) begin
			ra_s1 <= ra;
			rb_s1 <= rb;
		end
		if (rdv_s1)
			grid_q[ra_s1][rb_s1] <= rdata_s1;
		if (cmd.coef) begin
			for (int i = 0; i < 6; i++)
				c_q[i] <= c[i];
			acc_q <= c[stat.deg];
		end
		if (cmd.mul)
			prod_s1 <= prod_t'(acc_q) * prod_t'($signed({1'b0, u_cur}));
		if (cmd.add)
			acc_q <= acc_t'(rsum >>> FRAC_BITS) + c_q[cmd.k];
		if (cmd.fin) begin
			if (x_pass) begin
				if (fin > acc_t'((1 <<< (OUT_W - 1)) - 1))
					res_q <= {1'b0, {(OUT_W - 1){1'b1}}};
				else if (fin < -acc_t'(1 <<< (OUT_W - 1)))
					res_q <= {1'b1, {(OUT_W - 1){1'b0}}};
				else
					res_q <= fin[OUT_W-1:0];
			end else
				col_q[cmd.pass[1:0]] <= fin;
		end
	end

endmodule

// ===== hdl/subpixel_image_interpolator_core.sv =====
// Top level of the subpixel image interpolator.
//
// Input channel (in_valid/in_ready) carries one transaction per item: kind 0
// stores pixel_value at (pixel_col, pixel_row) of image image_select; kind 1
// queries image image_select at the 8.8 position (x_coord, y_coord).
// Writes outside the image or image range are dropped.
// Output channel (out_valid/out_ready) carries one transaction per query:
// interp_value (signed, FRAC_BITS fraction bits, saturated) and
// out_of_bounds, set when a neighbour was clamped to the border or the
// image number is out of range.
// cfg_we/cfg_data write interp_mode (0 bilinear, 1 bicubic, 2 quintic,
// 3 bicubic); write it only while the block is idle.
// A write leaves in_ready high. A query holds in_ready low until its
// result enters the output register: it reads its 4 or 16 neighbours from
// the single-port store (one neighbour per cycle), then runs 3 or 5 passes
// through the shared Horner unit.
// The result sits in an output register; a stalled receiver holds it while
// writes continue, and a further query waits until that register frees.
// Reset returns interp_mode to bicubic and clears the handshake state; the
// pixel store keeps no reset value and must be written before it is read.
module subpixel_image_interpolator_core
	import sii_pkg::*;
#(
	parameter int IMG_WIDTH  = 256,
	parameter int IMG_HEIGHT = 256,
	parameter int NUM_IMAGES = 2,
	parameter int FRAC_BITS  = 8,
	parameter int PIXEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    kind,
	input  logic                    image_select,
	input  logic [7:0]              pixel_col,
	input  logic [7:0]              pixel_row,
	input  logic [7:0]              pixel_value,
	input  logic [COORD_W-1:0]      x_coord,
	input  logic [COORD_W-1:0]      y_coord,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] interp_value,
	output logic                    out_of_bounds
);

	logic [1:0]              mode_q;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] value_q;
	logic                    oob_q;
	logic                    slot_free, push;
	sii_cmd_t                cmd;
	sii_stat_t               stat;
	logic signed [OUT_W-1:0] result;
	logic                    flag;

	// Output slot frees when empty or when the waiting result leaves now.
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CUBIC;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				mode_q <= cfg_data;
			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Hold the payload until the transaction completes.
	always_ff @(posedge clk) begin
		if (push) begin
			value_q <= result;
			oob_q   <= flag;
		end
	end

	assign out_valid     = out_valid_q;
	assign interp_value  = value_q;
	assign out_of_bounds = oob_q;

	sii_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.slot_free (slot_free),
		.stat      (stat),
		.in_ready  (in_ready),
		.push      (push),
		.cmd       (cmd)
	);

	sii_datapath #(
		.IMG_WIDTH  (IMG_WIDTH),
		.IMG_HEIGHT (IMG_HEIGHT),
		.NUM_IMAGES (NUM_IMAGES),
		.FRAC_BITS  (FRAC_BITS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (mode_q),
		.kind         (kind),
		.image_select (image_select),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row),
		.pixel_value  (pixel_value),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.stat         (stat),
		.result       (result),
		.flag         (flag)
	);

endmodule

// ===== hdl/sii_checker.sv =====
// Port-level checker for the interpolator core, bound to the top level.
module sii_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [17:0] interp_value
);

	// A query occupies the block for at least the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> !in_ready)
		else $error("in_ready high right after a query transaction");

	// A pixel write never takes the block out of idle.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !kind |=> in_ready)
		else $error("in_ready dropped after a write transaction");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(interp_value))
		else $error("stalled result changed or vanished");

endmodule

bind subpixel_image_interpolator_core sii_checker u_sii_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.kind         (kind),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.interp_value (interp_value)
);

// ===== tb/subpixel_image_interpolator_core_tb.sv =====
// Testbench for the subpixel image interpolator: pixel writes, queries in all kernels, self-checked.
`timescale 1ns / 1ps

module subpixel_image_interpolator_core_tb;
	import sii_pkg::*;

	localparam int FB = 8;

	// One input transaction as the driver presents it.
	typedef struct {
		logic        kind;
		logic        img;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [7:0]  pix;
		logic [15:0] xc;
		logic [15:0] yc;
	} item_t;

	// One result transaction.
	typedef struct {
		logic signed [OUT_W-1:0] value;
		logic                    oob;
	} result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic image_select;
	logic [7:0] pixel_col, pixel_row, pixel_value;
	logic [COORD_W-1:0] x_coord, y_coord;
	logic out_valid;
	logic out_ready;
	logic signed [OUT_W-1:0] interp_value;
	logic out_of_bounds;

	subpixel_image_interpolator_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.image_select (image_select),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row),
		.pixel_value  (pixel_value),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.interp_value (interp_value),
		.out_of_bounds(out_of_bounds)
	);

	// Shadow of the pixel store and the kernel register.
	logic [7:0] shadow_pix [0:1][0:255][0:255];
	bit         shadow_set [0:1][0:255][0:255];
	logic [1:0] shadow_mode;

	item_t   pending_items[$];
	result_t awaited_results[$];

	int  mismatches = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  recv_hold = 0;
	bit  stim_done = 0;

	// Clock: 8 ns period.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Round half up: floor((v + 2^(s-1)) / 2^s); >>> on a signed value floors.
	function automatic longint round_up_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// One 1D pass of the chosen kernel over p[0..3], fraction u.
	function automatic longint kernel_1d(longint p[4], logic [1:0] m, longint u);
		longint c[6];
		int     deg;
		longint acc;
		if (m == MODE_LINEAR) begin
			deg = 1;
			c[1] = 2 * (p[1] - p[0]);
			c[0] = 2 * p[0];
		end else if (m == MODE_QUINTIC) begin
			deg = 5;
			c[5] = 2*p[0] - 6*p[1] + 6*p[2] - 2*p[3];
			c[4] = -5*p[0] + 15*p[1] - 15*p[2] + 5*p[3];
			c[3] = 3*p[0] - 9*p[1] + 9*p[2] - 3*p[3];
			c[2] = p[0] - 2*p[1] + p[2];
			c[1] = p[2] - p[0];
			c[0] = 2 * p[1];
		end else begin
			deg = 3;
			c[3] = -p[0] + 3*p[1] - 3*p[2] + p[3];
			c[2] = 2*p[0] - 5*p[1] + 4*p[2] - p[3];
			c[1] = p[2] - p[0];
			c[0] = 2 * p[1];
		end
		acc = c[deg];
		for (int k = deg - 1; k >= 0; k--)
			acc = round_up_shift(acc * u, FB) + c[k];
		return round_up_shift(acc, 1);
	endfunction

	// Predict the answer to a query from the shadow store.
	function automatic result_t interpolate(item_t it);
		result_t r;
		logic [1:0] m;
		int     n, base, ix, iy, cx, ry;
		longint ux, uy, v;
		longint colv[4], rowv[4];
		bit     clamped;
		clamped = 0;
		m = (shadow_mode == MODE_LINEAR) ? MODE_LINEAR :
			(shadow_mode == MODE_QUINTIC) ? MODE_QUINTIC : MODE_CUBIC;
		ix = int'(it.xc[15:8]);
		iy = int'(it.yc[15:8]);
		ux = longint'(it.xc[7:0]);
		uy = longint'(it.yc[7:0]);
		n = (m == MODE_LINEAR) ? 2 : 4;
		base = (m == MODE_LINEAR) ? 0 : -1;
		colv = '{0, 0, 0, 0};
		for (int a = 0; a < n; a++) begin
			cx = ix + base + a;
			if (cx < 0) begin cx = 0; clamped = 1; end
			if (cx > 255) begin cx = 255; clamped = 1; end
			rowv = '{0, 0, 0, 0};
			for (int b = 0; b < n; b++) begin
				ry = iy + base + b;
				if (ry < 0) begin ry = 0; clamped = 1; end
				if (ry > 255) begin ry = 255; clamped = 1; end
				rowv[b] = longint'(shadow_pix[it.img][ry][cx]) << FB;
			end
			colv[a] = kernel_1d(rowv, m, uy);
		end
		v = kernel_1d(colv, m, ux);
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		r.value = v[OUT_W-1:0];
		r.oob = clamped;
		return r;
	endfunction

	// Driver: present the head of the queue, advance on each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (kind == KIND_WRITE) begin
					shadow_pix[image_select][pixel_row][pixel_col] = pixel_value;
				end else begin
					awaited_results.push_back(interpolate('{kind, image_select,
						pixel_col, pixel_row, pixel_value, x_coord, y_coord}));
				end
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item_t it;
					it = pending_items.pop_front();
					in_valid     <= 1'b1;
					kind         <= it.kind;
					image_select <= it.img;
					pixel_col    <= it.col;
					pixel_row    <= it.row;
					pixel_value  <= it.pix;
					x_coord      <= it.xc;
					y_coord      <= it.yc;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random ready, forced low while a hold-off runs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %0d oob %0b",
						interp_value, out_of_bounds);
			end else begin
				result_t e;
				e = awaited_results.pop_front();
				if (e.value !== interp_value || e.oob !== out_of_bounds) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %0d oob %0b, got value %0d oob %0b",
							e.value, e.oob, interp_value, out_of_bounds);
				end
			end
		end
	end

	// Record a pixel write in the set of written pixels and queue it.
	task automatic put_pixel(int img, int c, int r, int val);
		shadow_set[img][r][c] = 1;
		pending_items.push_back('{KIND_WRITE, img[0], c[7:0], r[7:0], val[7:0], 16'h0, 16'h0});
	endtask

	// True only where every neighbour of every kernel has been written.
	function automatic bit query_safe(int img, logic [15:0] xc, logic [15:0] yc);
		int ix, iy, cx, ry;
		ix = int'(xc[15:8]);
		iy = int'(yc[15:8]);
		for (int a = -1; a <= 2; a++)
			for (int b = -1; b <= 2; b++) begin
				cx = ix + a;
				ry = iy + b;
				cx = cx < 0 ? 0 : (cx > 255 ? 255 : cx);
				ry = ry < 0 ? 0 : (ry > 255 ? 255 : ry);
				if (!shadow_set[img][ry][cx])
					return 0;
			end
		return 1;
	endfunction

	task automatic put_query(int img, logic [15:0] xc, logic [15:0] yc);
		pending_items.push_back('{KIND_QUERY, img[0], 8'($urandom()), 8'($urandom()),
			8'($urandom()), xc, yc});
	endtask

	// Wait until every queued transaction went in and every result came out.
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Change the kernel while the block is idle; the shadow follows at the same edge.
	task automatic set_mode(logic [1:0] m);
		cfg_we   <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		shadow_mode = m;
		cfg_we <= 1'b0;
	endtask

	// A small rectangle of written pixels and random queries inside it.
	task automatic random_patch(int img, int nq);
		int x0, y0, w, h;
		logic [15:0] xc, yc;
		w = $urandom_range(4, 7);
		h = $urandom_range(4, 7);
		case ($urandom_range(3))
			0: begin x0 = 0; y0 = $urandom_range(0, 255 - h); end
			1: begin x0 = 256 - w; y0 = 256 - h; end
			default: begin
				x0 = $urandom_range(0, 256 - w);
				y0 = $urandom_range(0, 256 - h);
			end
		endcase
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				put_pixel(img, x0 + c, y0 + r,
					($urandom_range(3) == 0) ? 255 * $urandom_range(1) : $urandom_range(255));
		for (int q = 0; q < nq; q++) begin
			xc = {8'(x0 + $urandom_range(w - 1)), 8'($urandom())};
			yc = {8'(y0 + $urandom_range(h - 1)), 8'($urandom())};
			if (query_safe(img, xc, yc))
				put_query(img, xc, yc);
		end
	endtask

	// Stimulus, phases and configuration.
	initial begin
		logic [1:0] modes[4];
		int produced;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_data     = 2'd0;
		in_valid     = 1'b0;
		out_ready    = 1'b0;
		kind         = KIND_WRITE;
		image_select = 1'b0;
		pixel_col    = 8'd0;
		pixel_row    = 8'd0;
		pixel_value  = 8'd0;
		x_coord      = '0;
		y_coord      = '0;
		shadow_mode  = MODE_CUBIC;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: corners of both images with extreme pixels, edge and
		// corner queries so that clamping and overshoot both appear.
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				put_pixel(0, c, r, ((r + c) % 2) ? 255 : 0);
				put_pixel(1, 252 + c, 252 + r, (c == 1 && r == 1) ? 255 : 0);
			end
		put_query(0, 16'h0000, 16'h0000);
		put_query(0, 16'h0180, 16'h01ff);
		put_query(1, 16'hffff, 16'hffff);
		put_query(1, 16'hfd80, 16'hfd40);
		drain();

		// Sweep the kernels, the unused code among them.
		modes = '{MODE_LINEAR, MODE_QUINTIC, 2'd3, MODE_CUBIC};
		foreach (modes[i]) begin
			set_mode(modes[i]);
			put_query(0, 16'h0180, 16'h0140);
			put_query(1, 16'hfe80, 16'hfec0);
			put_query(1, 16'hff00, 16'hfd00);
			drain();
		end

		// Random phases: idling profile changes, kernel changes between phases.
		produced = 0;
		for (int ph = 0; ph < 24; ph++) begin
			send_idle_pct = (ph < 8) ? 12 : (ph < 16) ? 47 : 0;
			recv_idle_pct = (ph < 8) ? 47 : (ph < 16) ? 12 : 0;
			set_mode(2'($urandom_range(3)));
			for (int k = 0; k < 2; k++)
				random_patch($urandom_range(1), 12);
			// Hold off the receiver for a long stretch while queries pile up.
			if (ph == 5 || ph == 18) begin
				recv_hold = 1;
				repeat (400) @(posedge clk);
				recv_hold = 0;
			end
			drain();
		end
		stim_done = 1;
		drain();
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("subpixel_image_interpolator_core_tb: PASS");
		else
			$display("subpixel_image_interpolator_core_tb: FAIL");
		$finish;
	end

	// Limit the run.
	initial begin
		#20ms;
		$display("subpixel_image_interpolator_core_tb: FAIL");
		$finish;
	end

endmodule
